FILE: hdl/srd_pkg.sv
// shared types and constants for the scaled ratio divider
// no dependencies; used by every module under hdl
`default_nettype none

package srd_pkg;

  localparam int CNT_W   = 64;  // width of the done and total counts
  localparam int HALF_W  = 32;  // operand width of the shared multiplier
  localparam int RATIO_W = 20;  // width of the scaled ratio field
  localparam int PROD_W  = CNT_W + HALF_W;

  localparam logic [HALF_W-1:0] SCALE_DEFAULT = 32'd1000000;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/srd_mul32.sv
// 32 by 32 unsigned multiplier shared by both halves of done times scale
// depends on srd_pkg for the operand width
`default_nettype none

module srd_mul32 (
  input  wire logic [srd_pkg::HALF_W-1:0]   a,
  input  wire logic [srd_pkg::HALF_W-1:0]   b,
  output logic      [2*srd_pkg::HALF_W-1:0] prod
);

  always_comb begin
    prod = {{srd_pkg::HALF_W{1'b0}}, a} * {{srd_pkg::HALF_W{1'b0}}, b};
  end

endmodule

`default_nettype wire

FILE: hdl/srd_div_step.sv
// one restoring division step: shift remainder, compare with total, subtract
// depends on srd_pkg for the count width; QW comes from the top level
`default_nettype none

module srd_div_step #(
  parameter int QW = 20
) (
  input  wire logic [srd_pkg::CNT_W+QW-1:0] acc,
  input  wire logic [srd_pkg::CNT_W-1:0]    total,
  output logic      [srd_pkg::CNT_W+QW-1:0] acc_next
);

  localparam int AW = srd_pkg::CNT_W + QW;

  logic [srd_pkg::CNT_W:0]   shifted;
  logic [srd_pkg::CNT_W+1:0] diff;
  logic                      ge;
  logic [srd_pkg::CNT_W-1:0] rem_new;

  always_comb begin
    // remainder sits above the quotient bits; take the next dividend bit with it
    shifted  = acc[AW-1:QW-1];
    diff     = {1'b0, shifted} - {2'b00, total};
    ge       = ~diff[srd_pkg::CNT_W+1];
    rem_new  = ge ? diff[srd_pkg::CNT_W-1:0] : shifted[srd_pkg::CNT_W-1:0];
    acc_next = {rem_new, acc[QW-2:0], ge};
  end

endmodule

`default_nettype wire

FILE: hdl/scaled_ratio_divider.sv
// top level: sequencer, operand registers and result registers of the divider
// depends on srd_pkg, srd_mul32 and srd_div_step
//
// channel   direction  handshake              fields
// command   in         start, busy            done_count, total_count
// result    out        valid (one-cycle beat) scaled_ratio, status_code
//
// a beat runs ST_MUL_LO, ST_MUL_HI, ST_SUM and then QW restoring divide steps in ST_DIV,
// QW = clog2(SCALE+1) (at least 2); the divide loop is the longest part of a beat
// a done count above the total, or a zero total, returns from ST_MUL_LO and skips the divide
// ST_MUL_LO and ST_MUL_HI use the shared 32x32 multiplier in turn; ST_SUM loads the 96-bit sum
// busy stays high from the accepted start until the cycle valid pulses
// rst is synchronous and clears the sequencer and the result strobe
// the receiver cannot stall; each result is shown for exactly one cycle
`default_nettype none

module scaled_ratio_divider #(
  parameter logic [srd_pkg::HALF_W-1:0] SCALE = srd_pkg::SCALE_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [srd_pkg::CNT_W-1:0]   done_count,
  input  wire logic [srd_pkg::CNT_W-1:0]   total_count,
  output logic                             valid,
  output logic      [srd_pkg::RATIO_W-1:0] scaled_ratio,
  output logic                             status_code
);

  localparam int QW_RAW = $clog2({1'b0, SCALE} + 33'd1);
  localparam int QW     = (QW_RAW < 2) ? 2 : QW_RAW;
  localparam int AW     = srd_pkg::CNT_W + QW;
  localparam int CW     = $clog2(QW);
  localparam int HW     = srd_pkg::HALF_W;

  srd_pkg::state_t state, state_next;

  logic [srd_pkg::CNT_W-1:0]  done_r;
  logic [srd_pkg::CNT_W-1:0]  total_r;
  logic [2*HW-1:0]            p_lo;
  logic [2*HW-1:0]            p_hi;
  logic [AW-1:0]              acc;
  logic [AW-1:0]              acc_next;
  logic [CW-1:0]              cnt;
  logic [srd_pkg::PROD_W-1:0] sum;
  logic [HW-1:0]              mul_a;
  logic [2*HW-1:0]            prod;

  logic load_in, mul_hi_sel, store_lo, store_hi, load_acc, div_en;
  logic arg_bad, arg_zero, finish_early, finish_div;

  assign busy = (state != srd_pkg::ST_IDLE);

  assign arg_bad  = done_r > total_r;
  assign arg_zero = (total_r == '0);

  assign mul_a = mul_hi_sel ? done_r[srd_pkg::CNT_W-1:HW] : done_r[HW-1:0];

  srd_mul32 u_mul (
    .a    (mul_a),
    .b    (SCALE),
    .prod (prod)
  );

  srd_div_step #(.QW(QW)) u_step (
    .acc      (acc),
    .total    (total_r),
    .acc_next (acc_next)
  );

  // done * scale from the two partial products
  assign sum = {p_hi, {HW{1'b0}}} + {{HW{1'b0}}, p_lo};

  always_comb begin
    state_next = state;
    unique case (state)
      srd_pkg::ST_IDLE:   if (start) state_next = srd_pkg::ST_MUL_LO;
      srd_pkg::ST_MUL_LO: begin
        if (arg_bad || arg_zero) state_next = srd_pkg::ST_IDLE;
        else state_next = srd_pkg::ST_MUL_HI;
      end
      srd_pkg::ST_MUL_HI: state_next = srd_pkg::ST_SUM;
      srd_pkg::ST_SUM:    state_next = srd_pkg::ST_DIV;
      srd_pkg::ST_DIV:    if (cnt == '0) state_next = srd_pkg::ST_IDLE;
      default:            state_next = srd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    load_in      = 1'b0;
    mul_hi_sel   = 1'b0;
    store_lo     = 1'b0;
    store_hi     = 1'b0;
    load_acc     = 1'b0;
    div_en       = 1'b0;
    finish_early = 1'b0;
    finish_div   = 1'b0;
    unique case (state)
      srd_pkg::ST_IDLE:   load_in = start;
      srd_pkg::ST_MUL_LO: begin
        store_lo     = 1'b1;
        finish_early = arg_bad || arg_zero;
      end
      srd_pkg::ST_MUL_HI: begin
        mul_hi_sel = 1'b1;
        store_hi   = 1'b1;
      end
      srd_pkg::ST_SUM:    load_acc = 1'b1;
      srd_pkg::ST_DIV: begin
        div_en     = 1'b1;
        finish_div = (cnt == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srd_pkg::ST_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= finish_early || finish_div;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      done_r  <= done_count;
      total_r <= total_count;
    end
    if (store_lo) p_lo <= prod;
    if (store_hi) p_hi <= prod;
    // the quotient fits in QW bits, so the top of the product is zero
    if (load_acc) begin
      acc <= sum[AW-1:0];
      cnt <= CW'(QW - 1);
    end
    if (div_en) begin
      acc <= acc_next;
      cnt <= cnt - 1'b1;
    end
    if (finish_early) begin
      scaled_ratio <= '0;
      status_code  <= arg_bad ? srd_pkg::STATUS_INVALID : srd_pkg::STATUS_OK;
    end
    if (finish_div) begin
      scaled_ratio <= srd_pkg::RATIO_W'(acc_next[QW-1:0]);
      status_code  <= srd_pkg::STATUS_OK;
    end
  end

  a_valid_idle: assert property (@(posedge clk) disable iff (rst)
    valid |-> !busy)
    else $error("result beat while the sequencer is busy");

  a_valid_single: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid)
    else $error("two result beats in a row");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && status_code == srd_pkg::STATUS_INVALID) |-> scaled_ratio == '0)
    else $error("invalid status with a nonzero ratio");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

endmodule

`default_nettype wire
